// File: rtl/core/utf16d_pkg.sv
// Shared types and constants of the UTF-16 byte stream decoder.
package utf16d_pkg;

	localparam int unsigned ByteBits = 8;
	localparam int unsigned CpBits   = 21;
	localparam int unsigned PadBits  = 3;

	// Replacement character '?' and the first supplementary code point.
	localparam logic [CpBits-1:0] ReplChar   = 21'd63;
	localparam logic [CpBits-1:0] SuppOffset = 21'h10000;

	// Upper six bits of a 16-bit unit for high and low surrogates.
	localparam logic [5:0] HighSurPrefix = 6'b110110;
	localparam logic [5:0] LowSurPrefix  = 6'b110111;

	// One decoded result.
	typedef struct packed {
		logic [CpBits-1:0] code_point;
		logic              bad_sequence;
	} res_t;

	// Decoder state carried between bytes.
	typedef struct packed {
		logic                half_unit_held;
		logic [ByteBits-1:0] held_byte;
		logic                high_surrogate_held;
		logic [9:0]          held_high_bits;
	} dec_state_t;

endpackage

// File: rtl/core/utf16d_decode.sv
// Byte pairing, surrogate tracking and code point formation.
module utf16d_decode (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic [utf16d_pkg::ByteBits-1:0] byte_in,
	input  logic                           byte_swap,
	output logic                           res_valid,
	output utf16d_pkg::res_t               res
);

	utf16d_pkg::dec_state_t state_q;
	utf16d_pkg::dec_state_t state_next;
	logic [15:0]            unit;
	logic                   is_high;
	logic                   is_low;

	assign unit    = byte_swap ? {byte_in, state_q.held_byte} : {state_q.held_byte, byte_in};
	assign is_high = unit[15:10] == utf16d_pkg::HighSurPrefix;
	assign is_low  = unit[15:10] == utf16d_pkg::LowSurPrefix;

	always_comb begin
		state_next       = state_q;
		res_valid        = 1'b0;
		res.code_point   = utf16d_pkg::CpBits'(unit);
		res.bad_sequence = 1'b0;
		if (!state_q.half_unit_held) begin
			state_next.half_unit_held = 1'b1;
			state_next.held_byte      = byte_in;
		end else begin
			state_next.half_unit_held = 1'b0;
			if (state_q.high_surrogate_held) begin
				state_next.high_surrogate_held = 1'b0;
				res_valid                      = 1'b1;
				if (is_low) begin
					res.code_point = utf16d_pkg::SuppOffset
						+ utf16d_pkg::CpBits'({state_q.held_high_bits, unit[9:0]});
				end else begin
					res.code_point   = utf16d_pkg::ReplChar;
					res.bad_sequence = 1'b1;
				end
			end else if (is_high) begin
				state_next.high_surrogate_held = 1'b1;
				state_next.held_high_bits      = unit[9:0];
			end else if (is_low) begin
				res_valid        = 1'b1;
				res.code_point   = utf16d_pkg::ReplChar;
				res.bad_sequence = 1'b1;
			end else begin
				res_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

endmodule

// File: rtl/core/utf16d_out_reg.sv
// Result register in front of the output stream.
module utf16d_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  utf16d_pkg::res_t res_in,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output utf16d_pkg::res_t res_out
);

	logic             valid_q;
	utf16d_pkg::res_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// File: rtl/core/utf16_byte_stream_decoder.sv
// Top level of the UTF-16 byte stream decoder.
// The decoder takes one byte per transaction on the s_* stream and pairs
// bytes into 16-bit code units, high byte first unless byte_swap is set.
// Each complete unit that is not a surrogate is sent out as a code point on
// the m_* stream. A high surrogate is held until the next unit; with a low
// surrogate it forms a supplementary code point, otherwise '?' is sent with
// the bad_sequence flag and the second unit is dropped. A lone low
// surrogate also gives '?' with the flag set.
// The byte_swap register is written over the cfg_* channel, which is always
// ready; it should only be written while the decoder is idle.
// m_tvalid for a unit rises after its second byte has been accepted and has
// passed the input register and then the result register, whose output
// drives the m_* stream.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the single input register stage feeding the result register.
// Reset clears the byte pairing and surrogate state and byte_swap.
// When the receiver stalls, the result register holds its result, the
// input register holds the next byte if that byte would produce a result,
// and s_tready falls once both are occupied.
module utf16_byte_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic [0:0]  m_tuser,   // [0] bad_sequence
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // byte_swap
);

	logic                            byte_swap_q;
	logic                            valid_s1;
	logic [utf16d_pkg::ByteBits-1:0] byte_s1;
	logic                            advance;
	logic                            res_valid;
	logic                            out_free;
	utf16d_pkg::res_t                res;
	utf16d_pkg::res_t                res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_swap_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			byte_swap_q <= cfg_data;
		end
	end

	// The held byte leaves the input register when it causes no result or
	// when the result register can take its result.
	assign advance  = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	utf16d_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.byte_in   (byte_s1),
		.byte_swap (byte_swap_q),
		.res_valid (res_valid),
		.res       (res)
	);

	utf16d_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res_in    (res),
		.free      (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_out   (res_out)
	);

	assign m_tdata = {{utf16d_pkg::PadBits{1'b0}}, res_out.code_point};
	assign m_tuser = res_out.bad_sequence;

	// A replacement always carries the '?' code point.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[20:0] == utf16d_pkg::ReplChar)
		else $error("replacement without '?' code point");

	// A good result is never a surrogate code point.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[20:11] != 10'b0000011011)
		else $error("surrogate code point sent as good result");

	// A byte that cannot move on stays in the input register unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input byte lost");

endmodule
